FILE: src/hkrd_pkg.sv
// shared constants for the keyboard report differ
package hkrd_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int CODE_W        = 8;
  localparam int MOD_BITS      = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CODE_W-1:0]   MOD_USAGE_BASE = 8'hE0;
  localparam logic [MOD_BITS-1:0] SHIFT_MASK     = 8'h22;

endpackage

FILE: src/hkrd_front.sv
// front end: takes reports, diffs against the stored report, queues event masks
module hkrd_front
  import hkrd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF,
  localparam int KW = CODE_W * KEY_SLOTS,
  localparam int MW = 2 * KEY_SLOTS + MOD_BITS,
  localparam int EW = 2 * KW + MOD_BITS + MW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [CODE_W*(KEY_SLOTS+1)-1:0] in_tdata,
  output logic                            push,
  output logic [EW-1:0]                   push_data,
  input  logic                            q_full
);

  logic [KW-1:0]       prev_keys_r, prev_keys_nxt;
  logic [MOD_BITS-1:0] prev_mod_r, prev_mod_nxt;
  logic [KW-1:0]       cur_keys;
  logic [MOD_BITS-1:0] cur_mod;
  logic [MW-1:0]       mask;
  logic                accept;

  assign cur_mod   = in_tdata[MOD_BITS-1:0];
  assign cur_keys  = in_tdata[CODE_W +: KW];
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    logic in_prev;
    logic in_cur;
    mask = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      in_prev = 1'b0;
      in_cur  = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (cur_keys[CODE_W*i +: CODE_W] == prev_keys_r[CODE_W*j +: CODE_W]) begin
          in_prev = 1'b1;
        end
        if (prev_keys_r[CODE_W*i +: CODE_W] == cur_keys[CODE_W*j +: CODE_W]) begin
          in_cur = 1'b1;
        end
      end
      mask[2*i]   = (cur_keys[CODE_W*i +: CODE_W] != '0) && !in_prev;
      mask[2*i+1] = (prev_keys_r[CODE_W*i +: CODE_W] != '0) && !in_cur;
    end
    mask[2*KEY_SLOTS +: MOD_BITS] = cur_mod ^ prev_mod_r;
  end

  assign push      = accept && (mask != '0);
  assign push_data = {mask, cur_mod, prev_keys_r, cur_keys};

  always_comb begin
    prev_keys_nxt = prev_keys_r;
    prev_mod_nxt  = prev_mod_r;
    if (accept) begin
      prev_keys_nxt = cur_keys;
      prev_mod_nxt  = cur_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r <= '0;
      prev_mod_r  <= '0;
    end else begin
      prev_keys_r <= prev_keys_nxt;
      prev_mod_r  <= prev_mod_nxt;
    end
  end

endmodule

FILE: src/hkrd_queue.sv
// small register queue between front and back end
module hkrd_queue
  import hkrd_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] head
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/hkrd_back.sv
// back end: walks the event mask of one report, one event beat per cycle while out_tready allows
module hkrd_back
  import hkrd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF,
  localparam int KW = CODE_W * KEY_SLOTS,
  localparam int MW = 2 * KEY_SLOTS + MOD_BITS,
  localparam int EW = 2 * KW + MOD_BITS + MW,
  localparam int IW = $clog2(MW),
  localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  logic [EW-1:0]     q_head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CODE_W-1:0] out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  logic [MW-1:0]       mask_r, mask_nxt;
  logic [KW-1:0]       cur_r, cur_nxt;
  logic [KW-1:0]       prev_r, prev_nxt;
  logic [MOD_BITS-1:0] mod_r, mod_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic                pressed_r, pressed_nxt;
  logic                shift_r, shift_nxt;
  logic                last_r, last_nxt;

  logic          active, can_emit, fire, done;
  logic [MW-1:0] low, rem;
  logic [IW-1:0] idx;
  logic [SW-1:0] slot;
  logic [2:0]    mbit;
  logic [CODE_W-1:0] ev_code;
  logic              ev_pressed;

  assign active   = (mask_r != '0);
  assign can_emit = !out_valid_r || out_tready;
  assign fire     = active && can_emit;
  assign low      = mask_r & (~mask_r + MW'(1));
  assign rem      = mask_r & ~low;
  assign done     = fire && (rem == '0);
  assign pop      = q_valid && (!active || done);

  always_comb begin
    idx = '0;
    for (int j = 0; j < MW; j++) begin
      if (low[j]) begin
        idx = idx | IW'(j);
      end
    end
  end

  assign slot = SW'(idx >> 1);
  assign mbit = 3'(idx - IW'(2 * KEY_SLOTS));

  always_comb begin
    if (idx >= IW'(2 * KEY_SLOTS)) begin
      ev_code    = MOD_USAGE_BASE + {{(CODE_W-3){1'b0}}, mbit};
      ev_pressed = mod_r[mbit];
    end else if (idx[0]) begin
      ev_code    = prev_r[CODE_W*slot +: CODE_W];
      ev_pressed = 1'b0;
    end else begin
      ev_code    = cur_r[CODE_W*slot +: CODE_W];
      ev_pressed = 1'b1;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    mod_nxt  = mod_r;
    if (pop) begin
      cur_nxt  = q_head[KW-1:0];
      prev_nxt = q_head[KW +: KW];
      mod_nxt  = q_head[2*KW +: MOD_BITS];
      mask_nxt = q_head[2*KW+MOD_BITS +: MW];
    end else if (fire) begin
      mask_nxt = rem;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    pressed_nxt   = pressed_r;
    shift_nxt     = shift_r;
    last_nxt      = last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      code_nxt      = ev_code;
      pressed_nxt   = ev_pressed;
      shift_nxt     = |(mod_r & SHIFT_MASK);
      last_nxt      = (rem == '0);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    mod_r     <= mod_nxt;
    code_r    <= code_nxt;
    pressed_r <= pressed_nxt;
    shift_r   <= shift_nxt;
    last_r    <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = code_r;
  assign out_tuser  = {shift_r, pressed_r};
  assign out_tlast  = last_r;

  a_low_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    active |-> $onehot(low))
    else $error("event pick is not a single mask bit");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (last_r == $past(rem == '0)))
    else $error("emitted event or its last flag lost");

  a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> code_r != '0)
    else $error("event with empty usage code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> mask_r == '0 && !out_valid_r)
    else $error("back end busy after reset");

endmodule

FILE: src/hid_keyboard_report_differ_top.sv
// top level of the hid boot keyboard report differ
// usage:
//   in_*  : one boot keyboard report per beat, modifier byte in the low byte,
//           then one byte per key slot
//   out_* : key event beats, usage code in tdata, pressed and shift in tuser,
//           tlast on the final event of a report
// a report that matches the stored one gives no beats at all; otherwise it
// gives 1 to 2*KEY_SLOTS+8 beats (20 at the default of six slots)
// path: queue entry, then back end mask register, then output event register
// throughput: the back end emits one event per cycle while out_tready does not
// stall it; the two-entry queue lets the front take the next report right away
// and the back end pops it in the same cycle as it emits the previous final
// event
// reset: stored report cleared to zeros, queue and output register empty
// stall: while out_tready is low the event beat holds; the back end and then
// the queue fill, and in_tready drops only once the queue is full
module hid_keyboard_report_differ_top
  import hkrd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF,
  localparam int KW = CODE_W * KEY_SLOTS,
  localparam int MW = 2 * KEY_SLOTS + MOD_BITS,
  localparam int EW = 2 * KW + MOD_BITS + MW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [CODE_W*(KEY_SLOTS+1)-1:0] in_tdata,   // modifier_bits, key_0 .. key_n
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [CODE_W-1:0]               out_tdata,  // event_code
  output logic [1:0]                      out_tuser,  // pressed, shift_held
  output logic                            out_tlast
);

  logic          push, q_full, pop, q_valid;
  logic [EW-1:0] push_data, q_head;

  hkrd_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  hkrd_queue #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  hkrd_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: dv/hid_keyboard_report_differ_top_tb.sv
// self-checking testbench for the keyboard report differ: directed and random reports
module hid_keyboard_report_differ_top_tb
  import hkrd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = KEY_SLOTS_DEF;
  localparam int RW          = CODE_W * (SLOTS + 1);
  localparam int RANDOM_RPTS = 463;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [SLOTS-1:0][CODE_W-1:0] key_set_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              pressed;
    logic              shift;
    logic              last;
  } key_event_t;

  class key_event_predictor;
    key_set_t          stored_keys;
    logic [7:0]        stored_mods;
    key_event_t        pending_events[$];
    int                errors;
    int                reports;
    int                quiet_reports;
    int                events_seen;

    function new();
      stored_keys   = '0;
      stored_mods   = '0;
      errors        = 0;
      reports       = 0;
      quiet_reports = 0;
      events_seen   = 0;
    endfunction

    function bit has_code(input key_set_t keys, input logic [CODE_W-1:0] code);
      bit found;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) if (keys[i] == code) found = 1'b1;
      return found;
    endfunction

    function void take_report(input logic [RW-1:0] beat);
      key_set_t          cur_keys;
      logic [7:0]        cur_mod;
      logic [7:0]        changed;
      logic              shift;
      key_event_t        batch[$];
      cur_mod = beat[7:0];
      for (int i = 0; i < SLOTS; i++) cur_keys[i] = beat[CODE_W*(i+1) +: CODE_W];
      shift = |(cur_mod & SHIFT_MASK);
      for (int i = 0; i < SLOTS; i++) begin
        if (cur_keys[i] != '0 && !has_code(stored_keys, cur_keys[i]))
          batch.push_back('{code: cur_keys[i], pressed: 1'b1, shift: shift, last: 1'b0});
        if (stored_keys[i] != '0 && !has_code(cur_keys, stored_keys[i]))
          batch.push_back('{code: stored_keys[i], pressed: 1'b0, shift: shift, last: 1'b0});
      end
      changed = cur_mod ^ stored_mods;
      for (int n = 0; n < MOD_BITS; n++) begin
        if (changed[n])
          batch.push_back('{code: MOD_USAGE_BASE + CODE_W'(n), pressed: cur_mod[n],
                            shift: shift, last: 1'b0});
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      else quiet_reports++;
      foreach (batch[i]) pending_events.push_back(batch[i]);
      stored_keys = cur_keys;
      stored_mods = cur_mod;
      reports++;
    endfunction

    function void check_event(input logic [CODE_W-1:0] code, input logic [1:0] user,
                              input logic last);
      key_event_t want;
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event beat: code %0h pressed %0b shift %0b last %0b",
               code, user[0], user[1], last);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (code !== want.code) begin
        $error("event_code: expected %0h, got %0h", want.code, code);
        errors++;
      end
      if (user[0] !== want.pressed) begin
        $error("pressed: expected %0b, got %0b", want.pressed, user[0]);
        errors++;
      end
      if (user[1] !== want.shift) begin
        $error("shift_held: expected %0b, got %0b", want.shift, user[1]);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_event: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [RW-1:0]     in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [CODE_W-1:0] out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;

  key_event_predictor predictor = new();
  logic [RW-1:0]      last_report = '0;
  bit                 calm = 1'b0;
  int                 cycle_count = 0;

  hid_keyboard_report_differ_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) predictor.check_event(out_tdata, out_tuser, out_tlast);
      out_tready <= calm || ($urandom_range(99, 0) >= 17);
    end
  end

  function automatic logic [RW-1:0] report(input logic [7:0] mods, input logic [7:0] k0,
                                           input logic [7:0] k1, input logic [7:0] k2,
                                           input logic [7:0] k3, input logic [7:0] k4,
                                           input logic [7:0] k5);
    return {k5, k4, k3, k2, k1, k0, mods};
  endfunction

  function automatic logic [RW-1:0] next_report(input logic [RW-1:0] base);
    logic [RW-1:0]     r;
    logic [63:0]       wide;
    logic [CODE_W-1:0] tmp;
    int                kind;
    int                a;
    int                b;
    r    = base;
    kind = $urandom_range(99, 0);
    if (kind < 8) begin
      wide = {$urandom, $urandom};
      r    = wide[RW-1:0];
    end else if (kind < 12) begin
      r = '0;
    end else if (kind < 20) begin
      r = base;
    end else if (kind < 30) begin
      a = $urandom_range(SLOTS-1, 0);
      b = $urandom_range(SLOTS-1, 0);
      tmp = r[CODE_W*(a+1) +: CODE_W];
      r[CODE_W*(a+1) +: CODE_W] = r[CODE_W*(b+1) +: CODE_W];
      r[CODE_W*(b+1) +: CODE_W] = tmp;
    end else begin
      repeat ($urandom_range(3, 1)) begin
        a = $urandom_range(SLOTS-1, 0);
        case ($urandom_range(3, 0))
          0: r[CODE_W*(a+1) +: CODE_W] = '0;
          1: r[CODE_W*(a+1) +: CODE_W] = CODE_W'($urandom_range(12, 4));
          2: r[CODE_W*(a+1) +: CODE_W] = CODE_W'($urandom_range(255, 0));
          default: r[$urandom_range(7, 0)] = ~r[$urandom_range(7, 0)];
        endcase
      end
    end
    return r;
  endfunction

  task automatic send_report(input logic [RW-1:0] beat);
    while (!calm && $urandom_range(99, 0) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predictor.take_report(beat);
    last_report = beat;
  endtask

  task automatic drain_events();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (predictor.pending_events.size() != 0);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'hFF, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23));
    send_report(report(8'hFF, 8'h23, 8'h22, 8'h21, 8'h20, 8'h1F, 8'h1E));
    send_report(report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(report(8'h00, 8'hE0, 8'hE1, 8'hE5, 8'hE7, 8'h00, 8'h00));
    send_report(report(8'h02, 8'hE0, 8'hE1, 8'hE5, 8'hE7, 8'h00, 8'h00));
    send_report(report(8'h20, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h20, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h2A, 8'h2A, 8'h10, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h80, 8'h80, 8'h40, 8'h20, 8'h08, 8'h02, 8'h01));
    send_report(report(8'h55, 8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB));
    send_report(report(8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    for (int i = 0; i < RANDOM_RPTS; i++) begin
      calm = (i >= 150 && i < 250);
      if (i == 60 || i == 300) drain_events();
      send_report(next_report(last_report));
    end
    calm = 1'b0;

    drain_events();
    repeat (20) @(posedge clk);

    $display("ran %0d reports (%0d with no change), checked %0d key event beats",
             predictor.reports, predictor.quiet_reports, predictor.events_seen);
    if (predictor.pending_events.size() != 0) begin
      $error("%0d expected event beats never arrived", predictor.pending_events.size());
      predictor.errors++;
    end
    if (predictor.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", predictor.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
